/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BAP_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BAP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/bap_pkg.sv */
`default_nettype none

package bap_pkg;

    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 4;
    localparam int PIXEL_W      = CHAN_W * NUM_CHAN;
    localparam int SUM_W        = 20;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;
    localparam int BLK_IDX_W    = 11;
    localparam int MIN_BLOCK    = 2;

    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 13;
    localparam int BLOCK_REG_W  = 7;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [BLOCK_REG_W-1:0]  RST_BLOCK_SIZE   = 7'd8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_BLOCK   = 64;
    localparam int DEF_SUM_COLUMNS = 2048;

    typedef logic [NUM_CHAN-1:0][SUM_W-1:0] sums_t;

    // per-pixel control picked up at the input transfer
    typedef struct packed {
        logic                 first;
        logic                 done;
        logic                 frame_last;
        logic [BLK_IDX_W-1:0] block_col;
        logic [ROW_W-1:0]     row_pos;
    } pix_info_t;

    // finished block handed to the divider
    typedef struct packed {
        logic [BLK_IDX_W-1:0] block_col;
        logic [ROW_W-1:0]     row_pos;
        logic                 frame_last;
        logic [NUM_CHAN-1:0]  sat;
        sums_t                sums;
    } job_t;

endpackage

`default_nettype wire

/* rtl/bap_position.sv */
`default_nettype none

module bap_position #(
    parameter int MAX_WIDTH   = bap_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK   = bap_pkg::DEF_MAX_BLOCK,
    parameter int SUM_COLUMNS = bap_pkg::DEF_SUM_COLUMNS,
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int BW  = $clog2(MAX_BLOCK + 1),
    localparam int CW  = 2 * BW,
    localparam int SW  = $clog2(SUM_COLUMNS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [WW-1:0]             w_eff,
    input  wire logic [bap_pkg::ROW_W:0]   h_eff,
    input  wire logic [BW-1:0]             bs_eff,
    output bap_pkg::pix_info_t             info,
    output logic [SW-1:0]                  slot,
    output logic [CW-1:0]                  count
);

    localparam int CPW = $clog2(MAX_WIDTH);
    localparam int OW  = $clog2(MAX_BLOCK);

    logic [CPW-1:0]                  col_pos_reg;
    logic [bap_pkg::ROW_W-1:0]       row_pos_reg;
    logic [OW-1:0]                   ox_reg;
    logic [OW-1:0]                   oy_reg;
    logic [bap_pkg::BLK_IDX_W-1:0]   bci_reg;
    logic [SW-1:0]                   slot_reg;

    logic [BW-1:0] ox1;
    logic [BW-1:0] oy1;
    logic          row_end;
    logic          frame_end;
    logic          right;
    logic          bottom;

    always_comb
    begin
        ox1       = BW'(ox_reg) + 1'b1;
        oy1       = BW'(oy_reg) + 1'b1;
        row_end   = (WW'(col_pos_reg) + 1'b1) >= w_eff;
        frame_end = ((bap_pkg::ROW_W + 1)'(row_pos_reg) + 1'b1) >= h_eff;
        right     = (ox1 >= bs_eff) || row_end;
        bottom    = (oy1 >= bs_eff) || frame_end;
        count     = CW'(ox1) * CW'(oy1);

        info.first      = (ox_reg == '0) && (oy_reg == '0);
        info.done       = right && bottom;
        info.frame_last = row_end && frame_end;
        info.block_col  = bci_reg;
        info.row_pos    = row_pos_reg;
        slot            = slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            bci_reg     <= '0;
            slot_reg    <= '0;
        end
        else if (advance)
        begin
            if (row_end)
            begin
                col_pos_reg <= '0;
                ox_reg      <= '0;
                bci_reg     <= '0;
                slot_reg    <= '0;
                if (frame_end)
                begin
                    row_pos_reg <= '0;
                    oy_reg      <= '0;
                end
                else
                begin
                    row_pos_reg <= row_pos_reg + 1'b1;
                    oy_reg      <= bottom ? '0 : oy_reg + 1'b1;
                end
            end
            else
            begin
                col_pos_reg <= col_pos_reg + 1'b1;
                if (right)
                begin
                    ox_reg  <= '0;
                    bci_reg <= bci_reg + 1'b1;
                    // slot follows the block column modulo the store depth
                    if ((&bci_reg) || (slot_reg == SW'(SUM_COLUMNS - 1)))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                else
                begin
                    ox_reg <= ox_reg + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/bap_accum.sv */
`default_nettype none

`include "assert_macros.svh"

module bap_accum #(
    parameter int MAX_BLOCK   = bap_pkg::DEF_MAX_BLOCK,
    parameter int SUM_COLUMNS = bap_pkg::DEF_SUM_COLUMNS,
    localparam int BW = $clog2(MAX_BLOCK + 1),
    localparam int CW = 2 * BW,
    localparam int SW = $clog2(SUM_COLUMNS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_fire,
    input  wire logic [bap_pkg::PIXEL_W-1:0]   pixel_word,
    input  wire bap_pkg::pix_info_t            info,
    input  wire logic [SW-1:0]                 slot,
    input  wire logic [CW-1:0]                 count,
    input  wire logic                          launch_ok,
    output logic                               stall,
    output logic                               launch,
    output bap_pkg::job_t                      job,
    output logic [CW-1:0]                      job_count
);

    localparam int HI_W = bap_pkg::SUM_W - bap_pkg::CHAN_W;
    localparam int CMPW = (CW > HI_W) ? CW : HI_W;

    bap_pkg::sums_t sum_mem [SUM_COLUMNS];
    bap_pkg::sums_t rd_data_reg;

    logic                            b_valid_reg;
    bap_pkg::pix_info_t              b_info_reg;
    logic [SW-1:0]                   b_slot_reg;
    logic [CW-1:0]                   b_count_reg;
    logic [bap_pkg::PIXEL_W-1:0]     b_pixel_reg;

    logic                            byp_valid_reg;
    logic [SW-1:0]                   byp_slot_reg;
    bap_pkg::sums_t                  byp_data_reg;

    bap_pkg::sums_t                  old_sums;
    bap_pkg::sums_t                  new_sums;
    logic [bap_pkg::NUM_CHAN-1:0]    sat;
    logic                            advance_b;

    always_comb
    begin
        stall     = b_valid_reg && b_info_reg.done && !launch_ok;
        advance_b = b_valid_reg && !stall;
        launch    = advance_b && b_info_reg.done;

        // the write of the previous pixel is not yet visible in the read data
        if (byp_valid_reg && (byp_slot_reg == b_slot_reg))
        begin
            old_sums = byp_data_reg;
        end
        else
        begin
            old_sums = rd_data_reg;
        end

        for (int c = 0; c < bap_pkg::NUM_CHAN; c++)
        begin
            if (b_info_reg.first)
            begin
                new_sums[c] = bap_pkg::SUM_W'(b_pixel_reg[c*bap_pkg::CHAN_W +: bap_pkg::CHAN_W]);
            end
            else
            begin
                new_sums[c] = old_sums[c]
                    + bap_pkg::SUM_W'(b_pixel_reg[c*bap_pkg::CHAN_W +: bap_pkg::CHAN_W]);
            end
            // mean would exceed the channel range
            sat[c] = CMPW'(new_sums[c][bap_pkg::SUM_W-1:bap_pkg::CHAN_W]) >= CMPW'(b_count_reg);
        end

        job.block_col  = b_info_reg.block_col;
        job.row_pos    = b_info_reg.row_pos;
        job.frame_last = b_info_reg.frame_last;
        job.sat        = sat;
        job.sums       = new_sums;
        job_count      = b_count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg <= sum_mem[slot];
        end
        if (advance_b)
        begin
            sum_mem[b_slot_reg] <= new_sums;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (advance_b)
            begin
                b_valid_reg <= 1'b0;
            end
            if (advance_b)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_info_reg  <= info;
            b_slot_reg  <= slot;
            b_count_reg <= count;
            b_pixel_reg <= pixel_word;
        end
        if (advance_b)
        begin
            byp_slot_reg <= b_slot_reg;
            byp_data_reg <= new_sums;
        end
    end

    `BAP_ASSERT_NOW(a_no_fire_in_stall, stall, !in_fire, "pixel taken while update stage stalled")
    `BAP_ASSERT_NEXT(a_stall_holds, stall, b_valid_reg && $stable(b_slot_reg) && $stable(b_count_reg), "stalled update stage lost its pixel")

endmodule

`default_nettype wire

/* rtl/bap_divider.sv */
`default_nettype none

`include "assert_macros.svh"

module bap_divider #(
    parameter int MAX_BLOCK = bap_pkg::DEF_MAX_BLOCK,
    localparam int BW = $clog2(MAX_BLOCK + 1),
    localparam int CW = 2 * BW
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire bap_pkg::job_t                     job,
    input  wire logic [CW-1:0]                     count,
    input  wire logic [BW-1:0]                     bs,
    output logic                                   launch_ok,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bap_pkg::BLK_IDX_W-1:0]          block_col,
    output logic [bap_pkg::BLK_IDX_W-1:0]          block_row,
    output logic [bap_pkg::PIXEL_W-1:0]            mean_color,
    output logic                                   frame_last
);

    localparam int RW     = CW + 1;
    localparam int STEPS  = bap_pkg::ROW_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam int LANES  = bap_pkg::NUM_CHAN + 1;
    localparam int ROWL   = bap_pkg::NUM_CHAN;

    typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

    state_t                                state_reg;
    logic [STEP_W-1:0]                     step_reg;
    logic [LANES-1:0][RW-1:0]              rem_reg;
    logic [LANES-1:0][bap_pkg::ROW_W-1:0]  low_reg;
    logic [CW-1:0]                         count_reg;
    logic [BW-1:0]                         bs_reg;
    logic [bap_pkg::NUM_CHAN-1:0]          sat_reg;
    logic [bap_pkg::BLK_IDX_W-1:0]         block_col_reg;
    logic                                  frame_last_reg;

    logic [LANES-1:0][RW-1:0]              lane_div;
    logic [LANES-1:0][RW-1:0]              lane_try;
    logic [LANES-1:0]                      lane_ge;
    logic [LANES-1:0][RW-1:0]              rem_step;
    logic [LANES-1:0][bap_pkg::ROW_W-1:0]  low_step;

    // one restoring step per cycle in every lane: four channel means and the block row
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_div[i] = (i < ROWL) ? RW'(count_reg) : RW'(bs_reg);
            lane_try[i] = {rem_reg[i][RW-2:0], low_reg[i][bap_pkg::ROW_W-1]};
            lane_ge[i]  = lane_try[i] >= lane_div[i];
            rem_step[i] = lane_ge[i] ? (lane_try[i] - lane_div[i]) : lane_try[i];
            low_step[i] = {low_reg[i][bap_pkg::ROW_W-2:0], lane_ge[i]};
        end
    end

    always_comb
    begin
        launch_ok  = (state_reg == IDLE) || ((state_reg == HOLD) && out_ready);
        out_valid  = (state_reg == HOLD);
        block_col  = block_col_reg;
        block_row  = low_reg[ROWL][bap_pkg::BLK_IDX_W-1:0];
        frame_last = frame_last_reg;
        for (int c = 0; c < bap_pkg::NUM_CHAN; c++)
        begin
            mean_color[c*bap_pkg::CHAN_W +: bap_pkg::CHAN_W] =
                sat_reg[c] ? bap_pkg::CHAN_MAX : low_reg[c][bap_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            step_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                state_reg      <= RUN;
                step_reg       <= '0;
                count_reg      <= count;
                bs_reg         <= bs;
                sat_reg        <= job.sat;
                block_col_reg  <= job.block_col;
                frame_last_reg <= job.frame_last;
                for (int c = 0; c < bap_pkg::NUM_CHAN; c++)
                begin
                    // top bits are below the divisor whenever the mean fits
                    rem_reg[c] <= RW'(job.sums[c][bap_pkg::SUM_W-1:bap_pkg::ROW_W]);
                    low_reg[c] <= job.sums[c][bap_pkg::ROW_W-1:0];
                end
                rem_reg[ROWL] <= '0;
                low_reg[ROWL] <= job.row_pos;
            end
            else
            begin
                unique case (state_reg)
                    IDLE:
                    begin
                        state_reg <= IDLE;
                    end
                    RUN:
                    begin
                        rem_reg  <= rem_step;
                        low_reg  <= low_step;
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == STEP_W'(STEPS - 1))
                        begin
                            state_reg <= HOLD;
                        end
                    end
                    HOLD:
                    begin
                        if (out_ready)
                        begin
                            state_reg <= IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= IDLE;
                    end
                endcase
            end
        end
    end

    `BAP_ASSERT_NOW(a_start_when_free, start, (state_reg == IDLE) || ((state_reg == HOLD) && out_ready), "divider started while busy")
    `BAP_ASSERT_NEXT(a_start_runs, start, (state_reg == RUN) && (step_reg == '0), "divider did not begin a run")

endmodule

`default_nettype wire

/* rtl/block_average_pixelate.sv */
`default_nettype none

// Mosaic block averager. Packed RGBA pixels enter in raster order at one pixel per clock;
// four 20-bit channel sums per block column live in a SUM_COLUMNS-deep single-port-read,
// single-port-write sum memory that is read on the input transfer and written back from
// the registered update stage, with a one-entry bypass for back-to-back pixels of the same
// block column. The sum memory needs no clearing pass: the top-left pixel of each block
// overwrites its entry. When the bottom-right pixel of a block (clipped at the border) is
// summed, a shared restoring divider works out the four truncated means and the block row,
// one quotient bit per cycle; the result is held in its HOLD state until taken. in_ready
// drops only while a block-ending pixel waits for the divider, which is busy from its start
// until its result is taken: pixels stream at one per clock as long as each block end finds
// the divider free, and otherwise a block-ending pixel waits until the previous result is
// taken. Configuration writes are always taken; register values are saturated to their
// legal ranges at use.
module block_average_pixelate #(
    parameter int MAX_WIDTH   = bap_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK   = bap_pkg::DEF_MAX_BLOCK,
    parameter int SUM_COLUMNS = bap_pkg::DEF_SUM_COLUMNS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bap_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [bap_pkg::PIXEL_W-1:0]      pixel_word,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bap_pkg::BLK_IDX_W-1:0]         block_col,
    output logic [bap_pkg::BLK_IDX_W-1:0]         block_row,
    output logic [bap_pkg::PIXEL_W-1:0]           mean_color,
    output logic                                  frame_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int CW = 2 * BW;
    localparam int SW = $clog2(SUM_COLUMNS);

    logic [bap_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [bap_pkg::HEIGHT_REG_W-1:0] image_height_reg;
    logic [bap_pkg::BLOCK_REG_W-1:0]  block_size_reg;

    logic [WW-1:0]             w_eff;
    logic [bap_pkg::ROW_W:0]   h_eff;
    logic [BW-1:0]             bs_eff;

    logic                      in_fire;
    bap_pkg::pix_info_t        info;
    logic [SW-1:0]             slot;
    logic [CW-1:0]             count;
    logic                      stall;
    logic                      launch;
    logic                      launch_ok;
    bap_pkg::job_t             job;
    logic [CW-1:0]             job_count;

    assign cfg_ready = 1'b1;
    assign in_ready  = !stall;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bap_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= bap_pkg::RST_IMAGE_HEIGHT;
            block_size_reg   <= bap_pkg::RST_BLOCK_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bap_pkg::CFG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[bap_pkg::WIDTH_REG_W-1:0];
                end
                bap_pkg::CFG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data[bap_pkg::HEIGHT_REG_W-1:0];
                end
                bap_pkg::CFG_BLOCK_SIZE:
                begin
                    block_size_reg <= cfg_data[bap_pkg::BLOCK_REG_W-1:0];
                end
                default:
                begin
                    block_size_reg <= block_size_reg;
                end
            endcase
        end
    end

    // saturate the registers to their legal ranges
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            h_eff = (bap_pkg::ROW_W + 1)'(1);
        end
        else if (int'(image_height_reg) > bap_pkg::MAX_HEIGHT)
        begin
            h_eff = (bap_pkg::ROW_W + 1)'(bap_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = (bap_pkg::ROW_W + 1)'(image_height_reg);
        end

        if (int'(block_size_reg) < bap_pkg::MIN_BLOCK)
        begin
            bs_eff = BW'(bap_pkg::MIN_BLOCK);
        end
        else if (int'(block_size_reg) > MAX_BLOCK)
        begin
            bs_eff = BW'(MAX_BLOCK);
        end
        else
        begin
            bs_eff = BW'(block_size_reg);
        end
    end

    bap_position #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_BLOCK   (MAX_BLOCK),
        .SUM_COLUMNS (SUM_COLUMNS)
    ) u_position (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .bs_eff  (bs_eff),
        .info    (info),
        .slot    (slot),
        .count   (count)
    );

    bap_accum #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SUM_COLUMNS (SUM_COLUMNS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .pixel_word (pixel_word),
        .info       (info),
        .slot       (slot),
        .count      (count),
        .launch_ok  (launch_ok),
        .stall      (stall),
        .launch     (launch),
        .job        (job),
        .job_count  (job_count)
    );

    bap_divider #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (launch),
        .job        (job),
        .count      (job_count),
        .bs         (bs_eff),
        .launch_ok  (launch_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .block_col  (block_col),
        .block_row  (block_row),
        .mean_color (mean_color),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bap_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 480;
    localparam int MIN_PHASES    = 5;

    // index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [BLK_IDX_W-1:0] col;
        logic [BLK_IDX_W-1:0] row;
        logic [PIXEL_W-1:0]   mean;
        logic                 last;
    } block_avg_t;

    typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIXEL_W-1:0]    px;
        bit                    typed;
        block_avg_t            want;
    } plan_step_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [PIXEL_W-1:0]    pixel_word = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [BLK_IDX_W-1:0]  block_col;
    logic [BLK_IDX_W-1:0]  block_row;
    logic [PIXEL_W-1:0]    mean_color;
    logic                  frame_last;

    // mosaic model state
    logic [WIDTH_REG_W-1:0]  reg_width  = RST_IMAGE_WIDTH;
    logic [HEIGHT_REG_W-1:0] reg_height = RST_IMAGE_HEIGHT;
    logic [BLOCK_REG_W-1:0]  reg_block  = RST_BLOCK_SIZE;
    int unsigned             scan_x     = 0;
    int unsigned             scan_y     = 0;
    int unsigned             blk_off_x  = 0;
    int unsigned             blk_off_y  = 0;
    logic [BLK_IDX_W-1:0]    blk_x      = '0;
    logic [SUM_W-1:0]        chan_acc [DEF_SUM_COLUMNS][NUM_CHAN];

    block_avg_t pending_avgs[$];
    plan_step_t plan_steps[$];
    int         err_count     = 0;
    int         hold_requests = 0;
    int         holds_done    = 0;
    int         stall_cycles  = 0;
    bit         steady        = 1'b0;

    block_average_pixelate DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_word (pixel_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .block_col  (block_col),
        .block_row  (block_row),
        .mean_color (mean_color),
        .frame_last (frame_last)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // accumulates one pixel into its block column, returns 1 when a block closes
    function automatic bit average_pixel(input logic [PIXEL_W-1:0] px, output block_avg_t avg);
        int unsigned w, h, bs, slot, cnt, q;
        bit          first, row_end, frame_end, right, bottom;
        w         = clamp_u(reg_width, 1, DEF_MAX_WIDTH);
        h         = clamp_u(reg_height, 1, MAX_HEIGHT);
        bs        = clamp_u(reg_block, MIN_BLOCK, DEF_MAX_BLOCK);
        slot      = blk_x % DEF_SUM_COLUMNS;
        first     = (blk_off_x == 0) && (blk_off_y == 0);
        row_end   = (scan_x + 1 >= w);
        frame_end = (scan_y + 1 >= h);
        right     = (blk_off_x + 1 >= bs) || row_end;
        bottom    = (blk_off_y + 1 >= bs) || frame_end;
        cnt       = (blk_off_x + 1) * (blk_off_y + 1);
        avg       = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (first)
                chan_acc[slot][c] = SUM_W'(px[c*CHAN_W +: CHAN_W]);
            else
                chan_acc[slot][c] = chan_acc[slot][c] + SUM_W'(px[c*CHAN_W +: CHAN_W]);
            q = chan_acc[slot][c] / cnt;
            if (q > CHAN_MAX)
                q = CHAN_MAX;
            avg.mean[c*CHAN_W +: CHAN_W] = CHAN_W'(q);
        end
        avg.col  = blk_x;
        avg.row  = BLK_IDX_W'(scan_y / bs);
        avg.last = row_end && frame_end;

        if (row_end)
        begin
            scan_x    = 0;
            blk_off_x = 0;
            blk_x     = '0;
            if (frame_end)
            begin
                scan_y    = 0;
                blk_off_y = 0;
            end
            else
            begin
                scan_y++;
                blk_off_y = bottom ? 0 : blk_off_y + 1;
            end
        end
        else
        begin
            scan_x++;
            if (right)
            begin
                blk_off_x = 0;
                blk_x     = blk_x + 1'b1;
            end
            else
                blk_off_x++;
        end
        return right && bottom;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel(int ff_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ff_pct)
            return '1;
        if (r < ff_pct + 5)
            return '0;
        return $urandom;
    endfunction

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_step_t s;
        s      = '{kind: STEP_CFG, idx: idx, data: data, px: '0, typed: 1'b0, want: '0};
        plan_steps.push_back(s);
    endfunction

    function automatic void plan_pix(logic [PIXEL_W-1:0] px);
        plan_step_t s;
        s      = '{kind: STEP_PIXEL, idx: '0, data: '0, px: px, typed: 1'b0, want: '0};
        plan_steps.push_back(s);
    endfunction

    function automatic void plan_pix_typed(logic [PIXEL_W-1:0] px, logic [BLK_IDX_W-1:0] col,
                                           logic [BLK_IDX_W-1:0] row, logic [PIXEL_W-1:0] mean,
                                           logic last);
        plan_step_t s;
        s      = '{kind: STEP_PIXEL, idx: '0, data: '0, px: px, typed: 1'b1,
                   want: '{col: col, row: row, mean: mean, last: last}};
        plan_steps.push_back(s);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // stop offering pixels, wait for all block results, then let the pipe empty
    task automatic quiesce(input int extra);
        in_valid <= 1'b0;
        while (pending_avgs.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                             input bit last_one);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width  = data;
            CFG_IMAGE_HEIGHT: reg_height = data;
            CFG_BLOCK_SIZE:   reg_block  = data[BLOCK_REG_W-1:0];
            default: ;
        endcase
        if (last_one)
            cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input logic [PIXEL_W-1:0] px, input bit typed, input block_avg_t want);
        int         gap, r;
        block_avg_t avg;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!steady)
        begin
            if (r >= 95)
                gap = $urandom_range(10, 40);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_word <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (average_pixel(px, avg) || typed)
            pending_avgs.push_back(typed ? want : avg);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] b, input bit [3:0] mask,
                             input int frames, input int ff_pct, input int hold_at,
                             input bit pause_mid, output int items);
        logic [CFG_IDX_W-1:0]  order [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                    len;
        order = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_BLOCK_SIZE, CFG_SPARE};
        vals  = '{w, h, b, CFG_DATA_W'($urandom)};
        quiesce(SETTLE_CYCLES);
        for (int i = 0; i < 4; i++)
            if (mask[i])
                cfg_write(order[i], vals[i], (mask >> (i + 1)) == 0);
        len   = clamp_u(reg_width, 1, DEF_MAX_WIDTH) * clamp_u(reg_height, 1, MAX_HEIGHT);
        items = len * frames;
        for (int n = 0; n < items; n++)
        begin
            if (n == hold_at)
                hold_requests++;
            if (pause_mid && n == items / 2)
                quiesce(0);
            push_pixel(pick_pixel(ff_pct), 1'b0, '0);
        end
    endtask

    // receiver side: random ready with an occasional long hold-off
    initial
    begin
        int v, d, r;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                v = 0;
                d = HOLD_CYCLES;
            end
            else if (steady || r < 65)
            begin
                v = 1;
                d = steady ? 1 : $urandom_range(1, 4);
            end
            else if (r < 95)
            begin
                v = 0;
                d = $urandom_range(1, 3);
            end
            else
            begin
                v = 0;
                d = $urandom_range(15, 60);
            end
            out_ready <= v[0];
            repeat (d) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        block_avg_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {block_col, block_row, mean_color, frame_last};
            if (pending_avgs.size() == 0)
                flag_error($sformatf("unexpected block result col %0d row %0d",
                                     got.col, got.row));
            else
            begin
                want = pending_avgs.pop_front();
                if (got.col != want.col)
                    flag_error($sformatf("block_col %0d, want %0d", got.col, want.col));
                if (got.row != want.row)
                    flag_error($sformatf("block_row %0d, want %0d", got.row, want.row));
                if (got.mean != want.mean)
                    flag_error($sformatf("mean_color %h, want %h (block %0d,%0d)",
                                         got.mean, want.mean, want.col, want.row));
                if (got.last != want.last)
                    flag_error($sformatf("frame_last %0b, want %0b (block %0d,%0d)",
                                         got.last, want.last, want.col, want.row));
            end
        end
    end

    // counts cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int                    random_count, items, phase, hold_at;
        logic [CFG_DATA_W-1:0] w, h, blk;
        bit [3:0]              mask;
        bit                    pause_mid;
        foreach (chan_acc[i, c])
            chan_acc[i][c] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-pixel frames: the mean is the pixel itself, block size 0 saturates to 2
        plan_cfg(CFG_IMAGE_WIDTH, 13'd1);
        plan_cfg(CFG_IMAGE_HEIGHT, 13'd1);
        plan_cfg(CFG_BLOCK_SIZE, 13'd0);
        plan_cfg(CFG_SPARE, 13'h1555);
        plan_pix_typed(32'h0000_0000, 11'd0, 11'd0, 32'h0000_0000, 1'b1);
        plan_pix_typed(32'hFFFF_FFFF, 11'd0, 11'd0, 32'hFFFF_FFFF, 1'b1);
        plan_pix_typed(32'h5AC3_3CA5, 11'd0, 11'd0, 32'h5AC3_3CA5, 1'b1);
        // zero width and height saturate to one
        plan_cfg(CFG_IMAGE_WIDTH, 13'd0);
        plan_cfg(CFG_IMAGE_HEIGHT, 13'd0);
        plan_pix_typed(32'h1234_5678, 11'd0, 11'd0, 32'h1234_5678, 1'b1);
        // one full 2x2 block, truncated mean of 1,2,3,4
        plan_cfg(CFG_IMAGE_WIDTH, 13'd2);
        plan_cfg(CFG_IMAGE_HEIGHT, 13'd2);
        plan_cfg(CFG_BLOCK_SIZE, 13'd2);
        plan_pix(32'h0101_0101);
        plan_pix(32'h0202_0202);
        plan_pix(32'h0303_0303);
        plan_pix_typed(32'h0404_0404, 11'd0, 11'd0, 32'h0202_0202, 1'b1);
        // 3x3 frame, block 2 with upper data bits set: blocks clipped right and bottom
        plan_cfg(CFG_IMAGE_WIDTH, 13'd3);
        plan_cfg(CFG_IMAGE_HEIGHT, 13'd3);
        plan_cfg(CFG_BLOCK_SIZE, 13'h1F82);
        plan_pix(32'h1020_3040);
        plan_pix(32'hFFFF_FFFF);
        plan_pix(32'h0000_0000);
        plan_pix(32'h0102_0304);
        plan_pix(32'h8080_8080);
        plan_pix(32'h7F7F_7F7F);
        plan_pix(32'hDEAD_BEEF);
        plan_pix(32'h0F0F_0F0F);
        plan_pix(32'hF0F0_F0F0);

        foreach (plan_steps[i])
        begin
            if (plan_steps[i].kind == STEP_CFG)
            begin
                if (i == 0 || plan_steps[i-1].kind != STEP_CFG)
                    quiesce(SETTLE_CYCLES);
                cfg_write(plan_steps[i].idx, plan_steps[i].data,
                          (i == plan_steps.size() - 1) || plan_steps[i+1].kind != STEP_CFG);
            end
            else
                push_pixel(plan_steps[i].px, plan_steps[i].typed, plan_steps[i].want);
        end

        // one long row with the smallest block: many block columns in a row
        run_phase(13'd100, 13'd1, 13'd2, 4'b0111, 1, 5, -1, 1'b0, items);
        // 64-wide rows of mostly saturated pixels, block 127 saturates to 64
        run_phase(13'd64, 13'd2, 13'h1FFF, 4'b0111, 1, 90, -1, 1'b0, items);
        // one-pixel-wide column, block rows counting up
        run_phase(13'd1, 13'd60, 13'd2, 4'b0111, 1, 5, -1, 1'b0, items);

        random_count = 0;
        phase        = 0;
        while (random_count < RANDOM_ITEMS || phase < MIN_PHASES)
        begin
            w   = ($urandom_range(0, 19) == 0) ? 13'd0 : CFG_DATA_W'($urandom_range(1, 24));
            h   = CFG_DATA_W'($urandom_range(0, 10));
            blk = CFG_DATA_W'($urandom_range(0, 12));
            if ($urandom_range(0, 9) == 0)
                blk[CFG_DATA_W-1:BLOCK_REG_W] = (CFG_DATA_W - BLOCK_REG_W)'($urandom);
            mask      = (phase == 0 || $urandom_range(0, 99) < 80) ? 4'b0111
                                                                   : 4'($urandom_range(1, 15));
            steady    = ($urandom_range(0, 4) == 0);
            hold_at   = -1;
            pause_mid = (phase == 4);
            if (phase == 2)
            begin
                // small blocks with the receiver held off so the block backs up
                w       = 13'd16;
                h       = 13'd4;
                blk     = 13'd2;
                mask    = 4'b0111;
                steady  = 1'b1;
                hold_at = 10;
            end
            run_phase(w, h, blk, mask, $urandom_range(1, 2), 5, hold_at, pause_mid, items);
            random_count += items;
            phase++;
        end

        steady = 1'b0;
        quiesce(SETTLE_CYCLES);
        if (err_count == 0 && pending_avgs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* block_average_pixelate.f */
+incdir+rtl
rtl/bap_pkg.sv
rtl/bap_position.sv
rtl/bap_accum.sv
rtl/bap_divider.sv
rtl/block_average_pixelate.sv
sim/tb.sv
